// ----- src/sat_pkg.sv -----
// Package: shared types and codes of the sorted assignment table.
`default_nettype none

package sat_pkg;

  // Command codes of the input word.
  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_FIND  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // Status codes of the result word.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic [6:0] LIMIT_RESET = 7'd64;

  typedef struct packed {
    logic [1:0]  command;
    logic [63:0] domain_key;
    logic [7:0]  resolution;
    logic [63:0] tile_id;
    logic [31:0] shard_num;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] found_shard;
    logic [6:0]  entry_count;
    logic        overflow_seen;
  } out_word_t;

  typedef struct packed {
    logic [63:0] domain_key;
    logic [7:0]  resolution;
    logic [63:0] tile_id;
    logic [31:0] shard_num;
  } entry_t;

  typedef enum logic [2:0] {
    PTR_HOLD = 3'd0,
    PTR_TOP  = 3'd1,
    PTR_ZERO = 3'd2,
    PTR_DEC  = 3'd3,
    PTR_INC  = 3'd4
  } ptr_op_t;

  typedef struct packed {
    logic       key_load;
    ptr_op_t    ptr_op;
    logic       wr_en;
    logic       wr_key;
    logic       cnt_inc;
    logic       cnt_clr;
    logic       ovf_set;
    logic       ovf_clr;
    logic       res_load;
    logic [1:0] res_status;
    logic       res_hit;
    logic       out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic cnt_full;
    logic precedes;
    logic match;
    logic ptr_zero;
    logic ptr_last;
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- src/sat_ctrl.sv -----
// Controller state machine: sequences add, find and clear over the entry memory.
`default_nettype none

module sat_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire logic [1:0]      in_command,
  output logic                 in_stall,
  output logic                 out_valid,
  input  wire logic            out_stall,
  input  wire sat_pkg::dp_stat_t stat,
  output sat_pkg::ctl_cmd_t    cmd
);
  import sat_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_ADD  = 5'b00010,
    S_FIND = 5'b00100,
    S_INS  = 5'b01000,
    S_POST = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.key_load = 1'b1;
          case (in_command)
            CMD_ADD: begin
              if (stat.cnt_full) begin
                cmd.ovf_set    = 1'b1;
                cmd.res_load   = 1'b1;
                cmd.res_status = ST_FULL;
                state_nxt      = S_POST;
              end else if (stat.cnt_zero) begin
                cmd.ptr_op = PTR_ZERO;
                state_nxt  = S_INS;
              end else begin
                cmd.ptr_op = PTR_TOP;
                state_nxt  = S_ADD;
              end
            end
            CMD_FIND: begin
              if (stat.cnt_zero) begin
                cmd.res_load   = 1'b1;
                cmd.res_status = ST_MISS;
                state_nxt      = S_POST;
              end else begin
                cmd.ptr_op = PTR_ZERO;
                state_nxt  = S_FIND;
              end
            end
            CMD_CLEAR: begin
              cmd.cnt_clr    = 1'b1;
              cmd.ovf_clr    = 1'b1;
              cmd.res_load   = 1'b1;
              cmd.res_status = ST_OK;
              state_nxt      = S_POST;
            end
            default: begin
              cmd.res_load   = 1'b1;
              cmd.res_status = ST_OK;
              state_nxt      = S_POST;
            end
          endcase
        end
      end
      S_ADD: begin
        // Walk down from the top entry; entries not before the key move up one.
        if (stat.precedes) begin
          cmd.ptr_op = PTR_INC;
          state_nxt  = S_INS;
        end else begin
          cmd.wr_en = 1'b1;
          if (stat.ptr_zero) begin
            state_nxt = S_INS;
          end else begin
            cmd.ptr_op = PTR_DEC;
          end
        end
      end
      S_INS: begin
        cmd.wr_en      = 1'b1;
        cmd.wr_key     = 1'b1;
        cmd.cnt_inc    = 1'b1;
        cmd.res_load   = 1'b1;
        cmd.res_status = ST_OK;
        state_nxt      = S_POST;
      end
      S_FIND: begin
        if (stat.match) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_OK;
          cmd.res_hit    = 1'b1;
          state_nxt      = S_POST;
        end else if (stat.ptr_last) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_MISS;
          state_nxt      = S_POST;
        end else begin
          cmd.ptr_op = PTR_INC;
        end
      end
      S_POST: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- src/sat_dpath.sv -----
// Datapath: entry memory, key, pointer, count, flags, compare logic and output word.
`default_nettype none

module sat_dpath #(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire sat_pkg::in_word_t in_data,
  input  wire logic              cfg_we,
  input  wire logic [6:0]        cfg_wdata,
  input  wire sat_pkg::ctl_cmd_t cmd,
  output sat_pkg::dp_stat_t      stat,
  output sat_pkg::out_word_t     out_data
);
  import sat_pkg::*;

  localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;

  entry_t mem [TABLE_DEPTH];
  entry_t rd_data_r;
  entry_t wr_data;

  in_word_t         key_r;
  logic [AW-1:0]    ptr_r, ptr_nxt;
  logic [AW-1:0]    wr_addr;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] cnt_m1;
  logic             ovf_r, ovf_nxt;
  logic [6:0]       limit_r;
  logic [CMP_W-1:0] limit_eff;
  logic [1:0]       res_status_r;
  logic [31:0]      res_found_r;
  out_word_t        out_data_r;

  assign cnt_m1 = count_r - 1'b1;

  always_comb begin
    case (cmd.ptr_op)
      PTR_TOP:  ptr_nxt = cnt_m1[AW-1:0];
      PTR_ZERO: ptr_nxt = '0;
      PTR_DEC:  ptr_nxt = ptr_r - 1'b1;
      PTR_INC:  ptr_nxt = ptr_r + 1'b1;
      default:  ptr_nxt = ptr_r;
    endcase
  end

  // The key goes in at the pointer; a shifted entry moves to the slot above.
  assign wr_addr = cmd.wr_key ? ptr_r : ptr_r + 1'b1;
  assign wr_data = cmd.wr_key ?
                   '{domain_key: key_r.domain_key,
                     resolution: key_r.resolution,
                     tile_id:    key_r.tile_id,
                     shard_num:  key_r.shard_num} : rd_data_r;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[ptr_nxt];
  end

  assign limit_eff = (CMP_W'(limit_r) < CMP_W'(TABLE_DEPTH)) ?
                     CMP_W'(limit_r) : CMP_W'(TABLE_DEPTH);

  always_comb begin
    stat.cnt_zero = (count_r == '0);
    stat.cnt_full = (CMP_W'(count_r) >= limit_eff);
    if (rd_data_r.domain_key != key_r.domain_key) begin
      stat.precedes = rd_data_r.domain_key < key_r.domain_key;
    end else if (rd_data_r.resolution != key_r.resolution) begin
      stat.precedes = rd_data_r.resolution < key_r.resolution;
    end else begin
      stat.precedes = rd_data_r.tile_id < key_r.tile_id;
    end
    stat.match    = (rd_data_r.domain_key == key_r.domain_key) &&
                    (rd_data_r.tile_id == key_r.tile_id);
    stat.ptr_zero = (ptr_r == '0);
    stat.ptr_last = (ptr_r == cnt_m1[AW-1:0]);
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.cnt_clr) begin
      count_nxt = '0;
    end else if (cmd.cnt_inc) begin
      count_nxt = count_r + 1'b1;
    end
    ovf_nxt = ovf_r;
    if (cmd.ovf_clr) begin
      ovf_nxt = 1'b0;
    end else if (cmd.ovf_set) begin
      ovf_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
      limit_r <= LIMIT_RESET;
    end else begin
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    if (cmd.key_load) begin
      key_r <= in_data;
    end
    if (cmd.res_load) begin
      res_status_r <= cmd.res_status;
      res_found_r  <= cmd.res_hit ? rd_data_r.shard_num : 32'd0;
    end
    if (cmd.out_load) begin
      out_data_r.status        <= res_status_r;
      out_data_r.found_shard   <= res_found_r;
      out_data_r.entry_count   <= 7'(count_r);
      out_data_r.overflow_seen <= ovf_r;
    end
  end

  assign out_data = out_data_r;

endmodule

`default_nettype wire

// ----- src/sorted_assignment_table.sv -----
// Top level of the sorted assignment table.
//
// Input words carry a command (add, find, clear) and a key; every accepted word
// yields exactly one result word with status, found shard, entry count and the
// sticky overflow flag. Both channels use valid/stall; a word moves at a clock
// edge with valid high and stall low. The limit register is written through
// cfg_we/cfg_wdata; the user must write it only while the block is idle, as
// the block itself does not enforce it. One word is worked on at a time.
// Clear, an unknown command, a refused add and a find on an empty table go
// straight to the result state. An add walks down from the top entry, one
// entry per cycle through the single read port of the entry memory, moving
// each later entry up, then writes the key. A find walks up from entry 0
// until the first match or the last entry. An add walks at most 63 entries
// and a find at most 64.
// The result sits in an output register, so a stalled receiver does not hold
// the next input word back; that word's result waits until the register is
// free, and the input stalls meanwhile.
// Reset empties the table, clears the overflow flag and sets the limit to 64;
// the memory contents are not cleared, and no clearing pass is needed.
`default_nettype none

module sorted_assignment_table #(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire sat_pkg::in_word_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output sat_pkg::out_word_t      out_data,
  input  wire logic               cfg_we,
  input  wire logic [6:0]         cfg_wdata
);
  import sat_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  sat_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_data.command),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .stat       (stat),
    .cmd        (cmd)
  );

  sat_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // A finished result never overwrites one the receiver has not taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid || !out_stall))
    else $error("result register overwritten while stalled");

  // The table only grows while the count is below the limit.
  a_no_overgrow: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_inc |-> !stat.cnt_full)
    else $error("entry added beyond the limit");

  // The memory is written only while a word is in progress.
  a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_en |-> in_stall)
    else $error("memory written while idle");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/sorted_assignment_table_tb.sv -----
// Self-checking testbench for the sorted assignment table: table scoreboard, drivers, checks.
`default_nettype none

module sorted_assignment_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sat_pkg::*;

  localparam int          TABLE_DEPTH     = 64;
  localparam int          ITEMS_PER_PHASE = 205;
  localparam int          LONG_HOLD       = 400;
  localparam int          CYCLE_LIMIT     = 2_000_000;
  localparam logic [1:0]  CMD_UNKNOWN     = 2'd3;
  localparam logic [63:0] ALL_ONES        = '1;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  // Keeps its own copy of the table and the expected result words in order.
  class assignment_scoreboard;
    entry_t    rows [TABLE_DEPTH];
    int        held;
    bit        overflow;
    int        limit;
    out_word_t expected_q [$];
    int        errors;

    function new();
      held = 0;
      overflow = 1'b0;
      limit = LIMIT_RESET;
      errors = 0;
    endfunction

    function void note_command(in_word_t w);
      out_word_t r;
      int        cap;
      int        at;
      int        k;
      r = '0;
      r.status = ST_OK;
      cap = (limit < TABLE_DEPTH) ? limit : TABLE_DEPTH;
      case (w.command)
        CMD_ADD: begin
          if (held >= cap) begin
            overflow = 1'b1;
            r.status = ST_FULL;
          end else begin
            // The new entry lands in front of any entries equal to it.
            at = 0;
            while (at < held && {rows[at].domain_key, rows[at].resolution, rows[at].tile_id} <
                   {w.domain_key, w.resolution, w.tile_id})
              at++;
            for (k = held; k > at; k--) rows[k] = rows[k - 1];
            rows[at] = {w.domain_key, w.resolution, w.tile_id, w.shard_num};
            held++;
          end
        end
        CMD_FIND: begin
          r.status = ST_MISS;
          for (k = 0; k < held; k++) begin
            if (rows[k].domain_key == w.domain_key && rows[k].tile_id == w.tile_id) begin
              r.found_shard = rows[k].shard_num;
              r.status = ST_OK;
              break;
            end
          end
        end
        CMD_CLEAR: begin
          held = 0;
          overflow = 1'b0;
        end
        default: ;
      endcase
      r.entry_count = 7'(held);
      r.overflow_seen = overflow;
      expected_q.push_back(r);
    endfunction

    function void check_result(out_word_t got);
      out_word_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result word %h arrived with nothing expected", $time, got);
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status) begin
        errors++;
        $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
      end
      if (got.found_shard !== want.found_shard) begin
        errors++;
        $display("%0t: found_shard expected %h got %h", $time, want.found_shard,
                 got.found_shard);
      end
      if (got.entry_count !== want.entry_count) begin
        errors++;
        $display("%0t: entry_count expected %0d got %0d", $time, want.entry_count,
                 got.entry_count);
      end
      if (got.overflow_seen !== want.overflow_seen) begin
        errors++;
        $display("%0t: overflow_seen expected %0d got %0d", $time, want.overflow_seen,
                 got.overflow_seen);
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_word_t   in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_word_t  out_data;
  logic       cfg_we = 1'b0;
  logic [6:0] cfg_wdata = '0;

  idle_mode_t           idle_mode = IDLE_NONE;
  int                   hold_asked = 0;
  int                   hold_done = 0;
  int                   hold_left = 0;
  int                   cycle_count = 0;
  logic [127:0]         recent_keys [$];
  assignment_scoreboard table_sb;

  sorted_assignment_table #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #2ns clk = 1'b1;
    #2ns clk = 1'b0;
  end

  function automatic bit side_idles(bit receiver);
    int pct;
    case (idle_mode)
      IDLE_SENDER:   pct = receiver ? 0 : 57;
      IDLE_RECEIVER: pct = receiver ? 57 : 0;
      IDLE_BOTH:     pct = 21;
      default:       pct = 0;
    endcase
    return $urandom_range(0, 99) < pct;
  endfunction

  // Small values make equal keys and repeated lookups likely.
  function automatic logic [63:0] pick_id();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return ALL_ONES;
      2, 3:    return 64'($urandom_range(0, 3));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [7:0] pick_res();
    case ($urandom_range(0, 3))
      0:       return 8'($urandom_range(0, 2));
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off that fills the block up.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_done != hold_asked) begin
      out_stall <= 1'b1;
      hold_left <= LONG_HOLD;
      hold_done <= hold_asked;
    end else begin
      out_stall <= side_idles(1'b1);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) table_sb.note_command(in_data);
      if (out_valid && !out_stall) table_sb.check_result(out_data);
    end
  end

  task automatic issue(logic [1:0] cmd, logic [63:0] dom, logic [7:0] res,
                       logic [63:0] tile, logic [31:0] shard);
    while (side_idles(1'b0)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= {cmd, dom, res, tile, shard};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (table_sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(logic [6:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    table_sb.limit = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int           p;
    int           sent;
    int           burst;
    int           i;
    int           roll;
    logic [6:0]   lim;
    logic [63:0]  dom;
    logic [63:0]  tile;
    logic [127:0] key;
    table_sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_limit(LIMIT_RESET);
    issue(CMD_FIND, '0, '0, '0, '0);
    issue(CMD_UNKNOWN, ALL_ONES, 8'hFF, ALL_ONES, 32'hFFFF_FFFF);
    issue(CMD_ADD, '0, 8'h00, '0, 32'h0);
    issue(CMD_ADD, ALL_ONES, 8'hFF, ALL_ONES, 32'hFFFF_FFFF);
    // An equal entry goes in front, so the lookup must return the newer shard.
    issue(CMD_ADD, ALL_ONES, 8'hFF, ALL_ONES, 32'h1234_5678);
    issue(CMD_FIND, ALL_ONES, 8'h00, ALL_ONES, 32'hDEAD_BEEF);
    issue(CMD_ADD, ALL_ONES, 8'h00, ALL_ONES, 32'hA5A5_A5A5);
    issue(CMD_FIND, ALL_ONES, 8'h5A, ALL_ONES, '0);
    issue(CMD_FIND, '0, 8'hFF, '0, 32'hFFFF_FFFF);
    issue(CMD_FIND, '0, 8'h00, 64'd1, '0);
    issue(CMD_ADD, 64'd5, 8'd200, 64'd7, 32'd77);
    issue(CMD_ADD, 64'd5, 8'd100, 64'd9, 32'd88);
    issue(CMD_FIND, 64'd5, 8'd0, 64'd7, '0);
    issue(CMD_UNKNOWN, 64'd5, 8'd100, 64'd9, 32'd88);

    // Limit lowered below the number of held entries: they stay, adds are refused.
    wait_idle();
    write_limit(7'd2);
    issue(CMD_ADD, 64'd3, 8'd3, 64'd3, 32'd3);
    issue(CMD_FIND, 64'd5, 8'd0, 64'd9, '0);
    issue(CMD_UNKNOWN, '0, '0, '0, '0);
    issue(CMD_CLEAR, ALL_ONES, 8'hFF, ALL_ONES, 32'hFFFF_FFFF);
    issue(CMD_ADD, 64'd9, 8'd1, 64'd2, 32'd11);
    issue(CMD_ADD, 64'd9, 8'd1, 64'd1, 32'd12);
    issue(CMD_ADD, 64'd9, 8'd1, 64'd0, 32'd13);
    wait_idle();
    write_limit(7'd0);
    issue(CMD_CLEAR, '0, '0, '0, '0);
    issue(CMD_ADD, 64'd9, 8'd1, 64'd2, 32'd14);
    issue(CMD_FIND, 64'd9, 8'd1, 64'd2, '0);

    for (p = 0; p < 8; p++) begin
      case (p)
        0:       lim = 7'd64;
        1:       lim = 7'd1;
        2:       lim = 7'd127;
        3:       lim = 7'd5;
        4:       lim = 7'd0;
        5:       lim = 7'd100;
        6:       lim = 7'd64;
        default: lim = 7'd33;
      endcase
      wait_idle();
      write_limit(lim);
      idle_mode <= idle_mode_t'(p % 4);
      if (p == 0) hold_asked <= hold_asked + 1;
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        // Most bursts start from an empty table so that some of them fill it.
        burst = $urandom_range(5, 140);
        if ($urandom_range(0, 4) != 0) begin
          issue(CMD_CLEAR, pick_id(), pick_res(), pick_id(), $urandom);
          sent++;
        end
        for (i = 0; i < burst && sent < ITEMS_PER_PHASE; i++) begin
          roll = $urandom_range(0, 99);
          if (roll < 58) begin
            dom = pick_id();
            tile = pick_id();
            issue(CMD_ADD, dom, pick_res(), tile, $urandom);
            recent_keys.push_back({dom, tile});
            if (recent_keys.size() > 32) void'(recent_keys.pop_front());
          end else if (roll < 95) begin
            if (recent_keys.size() != 0 && $urandom_range(0, 3) != 0)
              key = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
            else
              key = {pick_id(), pick_id()};
            issue(CMD_FIND, key[127:64], pick_res(), key[63:0], $urandom);
          end else if (roll < 97) begin
            issue(CMD_UNKNOWN, pick_id(), pick_res(), pick_id(), $urandom);
          end else begin
            issue(CMD_CLEAR, pick_id(), pick_res(), pick_id(), $urandom);
          end
          sent++;
        end
      end
    end

    wait_idle();
    repeat (70) @(posedge clk);
    if (table_sb.errors == 0 && table_sb.expected_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
